// ===== src/plh_pkg.sv =====
// Shared types, constants and color table of the path loss heat map pixel block.
package plh_pkg;

  localparam int unsigned COORD_W = 9;
  localparam int unsigned SQ_W    = 19;
  localparam int unsigned LOSS_W  = 8;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned LOG_W   = 21;
  localparam int unsigned PROD_W  = 40;

  localparam logic [SQ_W-1:0] NEAR_LIMIT_SQ = 19'd100;
  localparam logic [SQ_W-1:0] BREAK_SQ      = 19'd55460;
  localparam logic [21:0]     NEAR_OFFSET   = 22'd3039085;
  localparam logic [18:0]     NEAR_SLOPE    = 19'd197579;
  localparam logic [18:0]     FAR_SLOPE     = 19'd394566;
  localparam logic [16:0]     FAR_OFFSET    = 17'd65267;

  localparam logic [COORD_W-1:0] TX_X_RST = 9'd20;
  localparam logic [COORD_W-1:0] TX_Y_RST = 9'd390;

  localparam logic [2:0] ADDR_TX_X = 3'd0;
  localparam logic [2:0] ADDR_TX_Y = 3'd4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic              valid;
    logic [LOSS_W-1:0] db;
  } loss_stat_t;

  function automatic rgb_t band_rgb(logic [LOSS_W-1:0] idx);
    rgb_t c;
    if (idx < 8'd35) begin
      c = '{8'd230, 8'd46, 8'd46};
    end else if (idx < 8'd45) begin
      c = '{8'd225, 8'd83, 8'd46};
    end else if (idx < 8'd50) begin
      c = '{8'd220, 8'd114, 8'd46};
    end else if (idx < 8'd55) begin
      c = '{8'd215, 8'd151, 8'd46};
    end else if (idx < 8'd60) begin
      c = '{8'd210, 8'd200, 8'd46};
    end else if (idx < 8'd65) begin
      c = '{8'd194, 8'd230, 8'd46};
    end else if (idx < 8'd70) begin
      c = '{8'd138, 8'd230, 8'd46};
    end else if (idx < 8'd75) begin
      c = '{8'd58, 8'd230, 8'd46};
    end else if (idx < 8'd80) begin
      c = '{8'd46, 8'd230, 8'd138};
    end else if (idx < 8'd85) begin
      c = '{8'd46, 8'd230, 8'd180};
    end else if (idx < 8'd90) begin
      c = '{8'd46, 8'd175, 8'd230};
    end else if (idx < 8'd95) begin
      c = '{8'd46, 8'd80, 8'd230};
    end else if (idx < 8'd100) begin
      c = '{8'd65, 8'd46, 8'd230};
    end else if (idx < 8'd105) begin
      c = '{8'd31, 8'd18, 8'd148};
    end else if (idx < 8'd110) begin
      c = '{8'd19, 8'd10, 8'd97};
    end else begin
      c = '{8'd0, 8'd0, 8'd0};
    end
    return c;
  endfunction

endpackage

// ===== src/plh_map_ram.sv =====
// One-bit wall map memory, one write port and one registered read port.
module plh_map_ram #(
  parameter int unsigned DEPTH = 262144,
  parameter int unsigned AW    = 18
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/plh_loss.sv =====
// Iterative log2 unit and two-slope path loss formula, whole dB result.
module plh_loss
  import plh_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SQ_W-1:0] dist_sq_i,
  output loss_stat_t      stat_o
);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_NORM = 3'd1;
  localparam logic [2:0] L_SQ   = 3'd2;
  localparam logic [2:0] L_MUL  = 3'd3;
  localparam logic [2:0] L_FIN  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [SQ_W-1:0]   n_q, n_d;
  logic [4:0]        k_q, k_d;
  logic [30:0]       m_q, m_d;
  logic [15:0]       frac_q, frac_d;
  logic [3:0]        i_q, i_d;
  logic              near_q, near_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              valid_q, valid_d;
  logic [LOSS_W-1:0] db_q, db_d;

  logic [61:0]       sq;
  logic [31:0]       sq_top;
  logic [LOG_W-1:0]  log_val;
  logic [18:0]       slope;
  logic [23:0]       t24;
  logic [25:0]       q;

  always_comb begin
    sq      = 62'(m_q) * 62'(m_q);
    sq_top  = sq[61:30];
    log_val = {k_q, frac_q};
    slope   = near_q ? NEAR_SLOPE : FAR_SLOPE;
    t24     = prod_q[39:16];
    if (near_q) begin
      q = 26'(NEAR_OFFSET) + 26'(t24);
    end else if (t24 > 24'(FAR_OFFSET)) begin
      q = 26'(t24 - 24'(FAR_OFFSET));
    end else begin
      q = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    k_d     = k_q;
    m_d     = m_q;
    frac_d  = frac_q;
    i_d     = i_q;
    near_d  = near_q;
    prod_d  = prod_q;
    valid_d = valid_q;
    db_d    = db_q;
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          valid_d = 1'b0;
          near_d  = dist_sq_i <= BREAK_SQ;
          n_d     = dist_sq_i;
          k_d     = 5'(SQ_W - 1);
          if (dist_sq_i < NEAR_LIMIT_SQ) begin
            db_d    = 8'd1;
            valid_d = 1'b1;
          end else begin
            state_d = L_NORM;
          end
        end
      end
      L_NORM: begin
        if (n_q[SQ_W-1]) begin
          m_d     = {n_q, 12'b0};
          frac_d  = '0;
          i_d     = 4'd15;
          state_d = L_SQ;
        end else begin
          n_d = {n_q[SQ_W-2:0], 1'b0};
          k_d = k_q - 5'd1;
        end
      end
      L_SQ: begin
        m_d    = sq_top[31] ? sq_top[31:1] : sq_top[30:0];
        frac_d = {frac_q[14:0], sq_top[31]};
        i_d    = i_q - 4'd1;
        if (i_q == 4'd0) begin
          state_d = L_MUL;
        end
      end
      L_MUL: begin
        prod_d  = PROD_W'(slope) * PROD_W'(log_val);
        state_d = L_FIN;
      end
      L_FIN: begin
        db_d    = q[23:16];
        valid_d = 1'b1;
        state_d = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    k_q    <= k_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    i_q    <= i_d;
    near_q <= near_d;
    prod_q <= prod_d;
    db_q   <= db_d;
  end

  assign stat_o = '{valid: valid_q, db: db_q};

endmodule

// ===== src/path_loss_heatmap_pixel_core.sv =====
// Top level: wall map control, wall walk, loss combine and color output.
//
// channel   direction  handshake                    payload
// in        input      in_valid_i / in_ready_o      func_i x_i y_i is_wall_i
// out       output     out_valid_o / out_ready_i    loss_index_o red_o green_o blue_o
// cfg       input      psel penable pwrite pready   paddr pwdata prdata
//
// A write transfer passes through the write state and back to idle. An evaluate
// transfer never ends before the log unit has its result; meanwhile
// the wall walk reads one map pixel per cycle from the single read port.
// Reset clears control state only; the wall map is not cleared.
// Input is taken only between items; a stalled result holds in the output
// register while the next input transfer is taken.
module path_loss_heatmap_pixel_core
  import plh_pkg::*;
#(
  parameter int unsigned GRID_DIM    = 512,
  parameter int unsigned LOSS_LEVELS = 200
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [COORD_W-1:0] x_i,
  input  logic [COORD_W-1:0] y_i,
  input  logic               is_wall_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LOSS_W-1:0]  loss_index_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned DEPTH = GRID_DIM * GRID_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] LOSS_MAX = CNT_W'(LOSS_LEVELS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WR    = 3'd1;
  localparam logic [2:0] S_RDPIX = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_WDONE = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  function automatic logic in_map(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    return (int'(cx) < GRID_DIM) && (int'(cy) < GRID_DIM);
  endfunction

  function automatic logic [AW-1:0] map_addr(logic [COORD_W-1:0] cx,
                                             logic [COORD_W-1:0] cy);
    return AW'(int'(cy) * GRID_DIM + int'(cx));
  endfunction

  function automatic logic [COORD_W-1:0] step_to(logic [COORD_W-1:0] v,
                                                 logic [COORD_W-1:0] t);
    logic [COORD_W-1:0] r;
    if (v < t) begin
      r = v + 1'b1;
    end else if (v > t) begin
      r = v - 1'b1;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [COORD_W-1:0] tx_x_q, tx_y_q;
  logic [2:0]         state_q, state_d;
  logic [COORD_W-1:0] x_q, y_q, a_q, a_d, c_q, c_d;
  logic [COORD_W-1:0] dx_q, dy_q;
  logic               wall_in_q, pix_wall_q, pix_wall_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rd_pend_q, rd_pend_d, inr_q, inr_d;
  logic               out_valid_q, out_valid_d;
  logic [LOSS_W-1:0]  loss_q, loss_d;
  rgb_t               rgb_q, rgb_d;

  logic               cfg_wr;
  logic               we;
  logic [AW-1:0]      raddr;
  logic               rdata;
  logic               loss_start;
  logic [SQ_W-1:0]    dist_sq;
  logic [17:0]        dx2, dy2;
  logic [COORD_W-1:0] na, nc;
  logic               arrive;
  logic [CNT_W-1:0]   sum;
  loss_stat_t         lstat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      ADDR_TX_Y[2]: prdata = 32'(tx_y_q);
      default:      prdata = 32'(tx_x_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_x_q <= TX_X_RST;
      tx_y_q <= TX_Y_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_TX_Y[2]) begin
        tx_y_q <= pwdata[COORD_W-1:0];
      end else begin
        tx_x_q <= pwdata[COORD_W-1:0];
      end
    end
  end

  assign dx2     = 18'(dx_q) * 18'(dx_q);
  assign dy2     = 18'(dy_q) * 18'(dy_q);
  assign dist_sq = SQ_W'(dx2) + SQ_W'(dy2);
  assign na      = step_to(a_q, tx_x_q);
  assign nc      = step_to(c_q, tx_y_q);
  assign arrive  = (na == tx_x_q) && (nc == tx_y_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign we      = (state_q == S_WR) && in_map(x_q, y_q);
  assign loss_start = (state_q == S_RDPIX);

  always_comb begin
    if (pix_wall_q) begin
      sum = LOSS_MAX;
    end else if (CNT_W'(lstat.db) > cnt_q) begin
      sum = CNT_W'(lstat.db) + cnt_q;
    end else begin
      sum = CNT_W'(lstat.db);
    end
    if (sum > LOSS_MAX) begin
      sum = LOSS_MAX;
    end
  end

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    c_d         = c_q;
    pix_wall_d  = pix_wall_q;
    cnt_d       = cnt_q;
    rd_pend_d   = 1'b0;
    raddr       = map_addr(x_q, y_q);
    inr_d       = in_map(x_q, y_q);
    out_valid_d = out_valid_q && !out_ready_i;
    loss_d      = loss_q;
    rgb_d       = rgb_q;
    if (rd_pend_q && inr_q && rdata) begin
      cnt_d = cnt_q + 1'b1;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = func_i ? S_RDPIX : S_WR;
        end
      end
      S_WR: state_d = S_IDLE;
      S_RDPIX: begin
        a_d     = x_q;
        c_d     = y_q;
        cnt_d   = '0;
        state_d = S_CHK;
      end
      S_CHK: begin
        pix_wall_d = rdata && inr_q;
        state_d    = (rdata && inr_q) ? S_WDONE : S_WALK;
      end
      S_WALK: begin
        if (arrive) begin
          state_d = S_WDONE;
        end else begin
          a_d       = na;
          c_d       = nc;
          raddr     = map_addr(na, nc);
          inr_d     = in_map(na, nc);
          rd_pend_d = 1'b1;
        end
      end
      S_WDONE: begin
        if (!rd_pend_q && lstat.valid) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          loss_d      = sum[LOSS_W-1:0];
          rgb_d       = band_rgb(sum[LOSS_W-1:0]);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (!inr_d) begin
      raddr = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      x_q       <= x_i;
      y_q       <= y_i;
      wall_in_q <= is_wall_i;
      dx_q      <= (x_i > tx_x_q) ? x_i - tx_x_q : tx_x_q - x_i;
      dy_q      <= (y_i > tx_y_q) ? y_i - tx_y_q : tx_y_q - y_i;
    end
    a_q        <= a_d;
    c_q        <= c_d;
    pix_wall_q <= pix_wall_d;
    cnt_q      <= cnt_d;
    inr_q      <= inr_d;
    loss_q     <= loss_d;
    rgb_q      <= rgb_d;
  end

  plh_map_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(map_addr(x_q, y_q)),
    .wdata_i(wall_in_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  plh_loss u_loss (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (loss_start),
    .dist_sq_i(dist_sq),
    .stat_o   (lstat)
  );

  assign out_valid_o  = out_valid_q;
  assign loss_index_o = loss_q;
  assign red_o        = rgb_q.red;
  assign green_o      = rgb_q.green;
  assign blue_o       = rgb_q.blue;

`ifndef SYNTHESIS
  a_pend_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == S_WALK || state_q == S_WDONE))
    else $error("walk read pending outside walk");
  a_fin_has_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |-> lstat.valid)
    else $error("combine without loss result");
  a_out_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> CNT_W'(loss_index_o) <= LOSS_MAX)
    else $error("loss index above saturation");
`endif

endmodule

// ===== dv/tb.sv =====
// Testbench for path_loss_heatmap_pixel_core: random wall map writes and pixel evaluates.
module tb
  import plh_pkg::*;
();

  localparam int MAP = 512;
  localparam int LEVEL_MAX = 199;
  localparam int FUNC_WRITE = 0;
  localparam int FUNC_EVAL = 1;
  localparam int ITEM_BUDGET = 1170;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [7:0] loss;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_color_t;

  class heatmap_scoreboard;
    bit wall[0:MAP*MAP-1];
    int unsigned txx = TX_X_RST;
    int unsigned txy = TX_Y_RST;
    pixel_color_t colors_due[$];
    int errors = 0;

    function void set_tx(int unsigned xx, int unsigned yy);
      txx = xx;
      txy = yy;
    endfunction

    function int unsigned log2_q16(longint unsigned n);
      int k;
      longint unsigned m;
      int unsigned r;
      k = 30;
      while (k > 0 && n[k] == 1'b0) k--;
      m = n << (30 - k);
      r = k << 16;
      for (int i = 15; i >= 0; i--) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          r = r | (1 << i);
        end
      end
      return r;
    endfunction

    function int unsigned base_loss_db(longint unsigned s);
      longint unsigned l, q, t;
      if (s < 100) return 1;
      l = log2_q16(s);
      if (s <= 55460) begin
        q = 3039085 + ((197579 * l) >> 16);
      end else begin
        t = (394566 * l) >> 16;
        q = (t > 65267) ? t - 65267 : 0;
      end
      return 32'(q >> 16);
    endfunction

    function int unsigned walls_on_path(int px, int py);
      int a, c;
      int unsigned n;
      a = px;
      c = py;
      n = 0;
      forever begin
        if (a < int'(txx)) a++; else if (a > int'(txx)) a--;
        if (c < int'(txy)) c++; else if (c > int'(txy)) c--;
        if (a == int'(txx) && c == int'(txy)) break;
        n += wall[c*MAP + a];
      end
      return n;
    endfunction

    function pixel_color_t predict_color(int px, int py);
      pixel_color_t e;
      int unsigned loss, walls, dx, dy, band;
      int unsigned tops[15] = '{35, 45, 50, 55, 60, 65, 70, 75, 80, 85, 90, 95, 100, 105, 110};
      logic [23:0] rgb[16] = '{
        {8'd230, 8'd46, 8'd46}, {8'd225, 8'd83, 8'd46}, {8'd220, 8'd114, 8'd46},
        {8'd215, 8'd151, 8'd46}, {8'd210, 8'd200, 8'd46}, {8'd194, 8'd230, 8'd46},
        {8'd138, 8'd230, 8'd46}, {8'd58, 8'd230, 8'd46}, {8'd46, 8'd230, 8'd138},
        {8'd46, 8'd230, 8'd180}, {8'd46, 8'd175, 8'd230}, {8'd46, 8'd80, 8'd230},
        {8'd65, 8'd46, 8'd230}, {8'd31, 8'd18, 8'd148}, {8'd19, 8'd10, 8'd97},
        {8'd0, 8'd0, 8'd0}};
      if (wall[py*MAP + px]) begin
        loss = LEVEL_MAX;
      end else begin
        dx = (px > int'(txx)) ? px - txx : txx - px;
        dy = (py > int'(txy)) ? py - txy : txy - py;
        loss = base_loss_db(dx*dx + dy*dy);
        walls = walls_on_path(px, py);
        if (loss > walls) loss += walls;
        if (loss > LEVEL_MAX) loss = LEVEL_MAX;
      end
      band = 0;
      while (band < 15 && loss >= tops[band]) band++;
      e.loss = loss[7:0];
      {e.r, e.g, e.b} = rgb[band];
      return e;
    endfunction

    function void note_transfer(bit fn, int px, int py, bit w);
      if (fn == FUNC_WRITE) wall[py*MAP + px] = w;
      else colors_due.push_back(predict_color(px, py));
    endfunction

    function void check_result(logic [7:0] l, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_color_t e;
      if (colors_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer loss=%0d", l);
        return;
      end
      e = colors_due.pop_front();
      if (l !== e.loss || r !== e.r || g !== e.g || b !== e.b) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp loss=%0d rgb=%0d,%0d,%0d got loss=%0d rgb=%0d,%0d,%0d",
                   e.loss, e.r, e.g, e.b, l, r, g, b);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, func_i, is_wall_i;
  logic [COORD_W-1:0] x_i, y_i;
  logic out_valid_o, out_ready_i;
  logic [LOSS_W-1:0] loss_index_o;
  logic [7:0] red_o, green_o, blue_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  heatmap_scoreboard sb = new();
  bit written[0:MAP*MAP-1];
  int items_sent = 0;
  longint cycles = 0;

  path_loss_heatmap_pixel_core dut (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    in_valid_i = 0; func_i = 0; x_i = '0; y_i = '0; is_wall_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    out_ready_i = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(loss_index_o, red_o, green_o, blue_o);

  initial begin
    int g;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 9) < 3) begin
        out_ready_i <= 1;
        repeat ($urandom_range(20, 200)) @(posedge clk_i);
      end else begin
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
        out_ready_i <= 0;
        repeat (g) @(posedge clk_i);
        out_ready_i <= 1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

  // unwritten map entries that an evaluate of (px,py) would need
  function automatic int path_cost(int px, int py);
    int a, c, n;
    a = px;
    c = py;
    n = written[py*MAP + px] ? 0 : 1;
    forever begin
      if (a < int'(sb.txx)) a++; else if (a > int'(sb.txx)) a--;
      if (c < int'(sb.txy)) c++; else if (c > int'(sb.txy)) c--;
      if (a == int'(sb.txx) && c == int'(sb.txy)) break;
      if (!written[c*MAP + a]) n++;
    end
    return n;
  endfunction

  function automatic int near_coord(int t);
    int v;
    v = t + int'($urandom_range(0, 24)) - 12;
    if (v < 0) v = 0;
    if (v > MAP-1) v = MAP-1;
    return v;
  endfunction

  task automatic send_item(bit fn, int px, int py, bit w);
    int g;
    in_valid_i <= 1;
    func_i <= fn;
    x_i <= COORD_W'(px);
    y_i <= COORD_W'(py);
    is_wall_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_transfer(fn, px, py, w);
    items_sent++;
    if (fn == FUNC_WRITE) written[py*MAP + px] = 1;
    g = $urandom_range(0, 9);
    g = (g < 6) ? 0 : (g < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic fill_pixel(int px, int py);
    if (!written[py*MAP + px])
      send_item(FUNC_WRITE, px, py, $urandom_range(0, 7) == 0);
  endtask

  // every map entry the evaluate reads is written first
  task automatic evaluate(int px, int py);
    int a, c;
    fill_pixel(px, py);
    a = px;
    c = py;
    forever begin
      if (a < int'(sb.txx)) a++; else if (a > int'(sb.txx)) a--;
      if (c < int'(sb.txy)) c++; else if (c > int'(sb.txy)) c--;
      if (a == int'(sb.txx) && c == int'(sb.txy)) break;
      fill_pixel(a, c);
    end
    send_item(FUNC_EVAL, px, py, $urandom_range(0, 1));
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.colors_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] addr, int unsigned val);
    logic [31:0] d;
    d = $urandom();
    d[8:0] = val[8:0];
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= d;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_transmitter(int unsigned xx, int unsigned yy);
    drain();
    reg_write(ADDR_TX_X, xx);
    reg_write(ADDR_TX_Y, yy);
    sb.set_tx(xx, yy);
  endtask

  task automatic random_phase(int n);
    int stop, k, px, py;
    stop = items_sent + n;
    while (items_sent < stop) begin
      k = $urandom_range(0, 9);
      if (k < 3) begin
        px = $urandom_range(0, MAP-1);
        py = $urandom_range(0, MAP-1);
        send_item(FUNC_WRITE, px, py, $urandom_range(0, 3) == 0);
      end else begin
        if (k < 5) begin
          px = near_coord(int'(sb.txx));
          py = near_coord(int'(sb.txy));
        end else if (k == 5) begin
          px = $urandom_range(0, 1) ? MAP-1 : 0;
          py = $urandom_range(0, MAP-1);
        end else begin
          px = $urandom_range(0, MAP-1);
          py = $urandom_range(0, MAP-1);
        end
        // long unwritten paths would blow the item count
        if (items_sent + path_cost(px, py) + 1 > stop) begin
          px = near_coord(int'(sb.txx));
          py = near_coord(int'(sb.txy));
        end
        evaluate(px, py);
      end
    end
  endtask

  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);
    // reset transmitter: on tx, near, wall pixel, both slopes; then tx at corner 0,0
    evaluate(TX_X_RST, TX_Y_RST);
    evaluate(TX_X_RST + 3, TX_Y_RST - 2);
    send_item(FUNC_WRITE, 25, 380, 1);
    evaluate(25, 380);
    send_item(FUNC_WRITE, 25, 380, 0);
    evaluate(25, 380);
    evaluate(TX_X_RST + 10, TX_Y_RST);
    evaluate(TX_X_RST + 170, TX_Y_RST - 170);
    set_transmitter(0, 0);
    evaluate(0, 0);
    random_phase(150);
    set_transmitter(511, 511);
    random_phase(150);
    set_transmitter(0, 511);
    random_phase(150);
    set_transmitter(511, 0);
    random_phase(150);
    set_transmitter(256, 256);
    random_phase(150);
    while (items_sent < ITEM_BUDGET) begin
      set_transmitter($urandom_range(0, MAP-1), $urandom_range(0, MAP-1));
      random_phase((ITEM_BUDGET - items_sent < 120) ? ITEM_BUDGET - items_sent : 120);
    end
    drain();
    if (sb.errors == 0 && sb.colors_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/plh_pkg.sv
src/plh_map_ram.sv
src/plh_loss.sv
src/path_loss_heatmap_pixel_core.sv
dv/tb.sv
